### rtl/core/awlm_pkg.sv
// Shared constants, codes and controller/datapath command types for the level monitor.
`timescale 1ns / 1ps

package awlm_pkg;

    localparam int WINDOW      = 40;
    localparam int SAMPLE_BITS = 12;

    localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W    = 6;
    localparam int PCT_W     = 7;
    localparam int DIAG_W    = 3;
    localparam int CFG_IDX_W = 3;

    // Window sum and percent numerator widths
    localparam int SUM_W   = $clog2(WINDOW * ((2 ** SAMPLE_BITS) - 1) + 1);
    localparam int NUM_W   = SAMPLE_BITS + PCT_W;
    localparam int DVD_RAW = (SUM_W > NUM_W) ? SUM_W : NUM_W;
    localparam int DVD_W   = DVD_RAW + (DVD_RAW % 2);
    localparam int DSR_W   = (SAMPLE_BITS > FILL_W) ? SAMPLE_BITS : FILL_W;

    // Divider retires two quotient bits per cycle
    localparam int DIV_STEPS = DVD_W / 2;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

    localparam logic [SAMPLE_BITS-1:0] EMPTY_RST  = SAMPLE_BITS'(0);
    localparam logic [SAMPLE_BITS-1:0] FULL_RST   = SAMPLE_BITS'(4095);
    localparam logic [SAMPLE_BITS-1:0] SPREAD_RST = SAMPLE_BITS'(400);
    localparam logic [SAMPLE_BITS-1:0] LOW_RST    = SAMPLE_BITS'(40);
    localparam logic [SAMPLE_BITS-1:0] HIGH_RST   = SAMPLE_BITS'(4050);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMPTY_LEVEL  = 3'd0,
        CFG_FULL_LEVEL   = 3'd1,
        CFG_SPREAD_LIMIT = 3'd2,
        CFG_LOW_LIMIT    = 3'd3,
        CFG_HIGH_LIMIT   = 3'd4
    } cfg_idx_t;

    typedef enum logic [DIAG_W-1:0] {
        DIAG_WARMING    = 3'd0,
        DIAG_UNSTABLE   = 3'd1,
        DIAG_STUCK_LOW  = 3'd2,
        DIAG_STUCK_HIGH = 3'd3,
        DIAG_STABLE     = 3'd4
    } diag_t;

    typedef struct packed {
        logic accept;
        logic scan;
        logic div_load_mean;
        logic div_step;
        logic mean_latch;
        logic pct_setup;
        logic pct_latch;
        logic load_out;
    } awlm_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic pct_direct;
        logic out_free;
    } awlm_status_t;

endpackage

### rtl/core/awlm_if.sv
// Handshake interfaces for the sample, result and configuration channels.
`timescale 1ns / 1ps

interface awlm_sample_if import awlm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface awlm_result_if import awlm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] window_min;
    logic [SAMPLE_BITS-1:0] window_max;
    logic [SAMPLE_BITS-1:0] window_mean;
    logic [SAMPLE_BITS-1:0] window_spread;
    logic [PCT_W-1:0]       tank_percent;
    logic [DIAG_W-1:0]      diagnosis;
    logic [FILL_W-1:0]      fill_level;

    modport source (output valid, output window_min, output window_max,
                    output window_mean, output window_spread, output tank_percent,
                    output diagnosis, output fill_level, input ready);
    modport sink   (input valid, input window_min, input window_max,
                    input window_mean, input window_spread, input tank_percent,
                    input diagnosis, input fill_level, output ready);
endinterface

interface awlm_cfg_if import awlm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [SAMPLE_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/awlm_ctrl.sv
// Level monitor sequencer: accept, scan, one or two divides, result load.
`timescale 1ns / 1ps

module awlm_ctrl import awlm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  awlm_status_t status,
    output awlm_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_DIVM = 6'b000100,
        ST_PCT  = 6'b001000,
        ST_DIVP = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    cmd.div_load_mean = 1'b1;
                    state_next        = ST_DIVM;
                end
            end
            ST_DIVM:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    cmd.mean_latch = 1'b1;
                    state_next     = ST_PCT;
                end
            end
            ST_PCT:
            begin
                cmd.pct_setup = 1'b1;
                state_next    = status.pct_direct ? ST_OUT : ST_DIVP;
            end
            ST_DIVP:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    cmd.pct_latch = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/awlm_dp.sv
// Datapath: sample ring, scan accumulator, shared divider, config and result registers.
`timescale 1ns / 1ps

module awlm_dp import awlm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  awlm_cmd_t              cmd,
    output awlm_status_t           status,
    awlm_cfg_if.sink               cfg,
    awlm_result_if.source          results
);

    // Sample ring
    logic [SAMPLE_BITS-1:0] mem [WINDOW];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [PTR_W-1:0]       rd_addr;

    // Control state
    logic [PTR_W-1:0]  wpos_reg, wpos_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] issue_reg, issue_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic              out_valid_reg, out_valid_next;

    // Configuration
    logic [SAMPLE_BITS-1:0] empty_reg, full_reg, spread_lim_reg, low_lim_reg, high_lim_reg;

    // Payload
    logic [SAMPLE_BITS-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [DSR_W-1:0]       rem_reg, rem_next, dsr_reg, dsr_next;
    logic [DVD_W-1:0]       quo_reg, quo_next;
    logic [SAMPLE_BITS-1:0] mean_reg, mean_next;
    logic [PCT_W-1:0]       pct_reg, pct_next;

    logic [SAMPLE_BITS-1:0] o_min_reg, o_max_reg, o_mean_reg, o_spread_reg;
    logic [PCT_W-1:0]       o_pct_reg;
    logic [DIAG_W-1:0]      o_diag_reg;
    logic [FILL_W-1:0]      o_fill_reg;

    logic                   issuing;
    logic                   pct_direct;
    logic [SAMPLE_BITS-1:0] spread;
    diag_t                  diag;
    logic [NUM_W-1:0]       pct_num;

    // Two restoring divide iterations per cycle
    logic [DSR_W:0]   trial1, trial2;
    logic [DSR_W-1:0] rem1, rem2;
    logic             qbit1, qbit2;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg      <= EMPTY_RST;
            full_reg       <= FULL_RST;
            spread_lim_reg <= SPREAD_RST;
            low_lim_reg    <= LOW_RST;
            high_lim_reg   <= HIGH_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_EMPTY_LEVEL:  empty_reg      <= cfg.data;
                CFG_FULL_LEVEL:   full_reg       <= cfg.data;
                CFG_SPREAD_LIMIT: spread_lim_reg <= cfg.data;
                CFG_LOW_LIMIT:    low_lim_reg    <= cfg.data;
                CFG_HIGH_LIMIT:   high_lim_reg   <= cfg.data;
                default:          ;
            endcase
        end
    end

    assign issuing = cmd.scan && (issue_reg < fill_reg);
    assign rd_addr = issue_reg[PTR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mem[wpos_reg] <= sample;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign pct_direct = (mean_reg <= empty_reg) || (mean_reg >= full_reg);
    assign spread     = hi_reg - lo_reg;
    assign pct_num    = NUM_W'(mean_reg - empty_reg) * NUM_W'(PCT_FULL);

    always_comb
    begin
        trial1 = {rem_reg, quo_reg[DVD_W-1]};
        qbit1  = (trial1 >= {1'b0, dsr_reg});
        rem1   = qbit1 ? DSR_W'(trial1 - {1'b0, dsr_reg}) : trial1[DSR_W-1:0];
        trial2 = {rem1, quo_reg[DVD_W-2]};
        qbit2  = (trial2 >= {1'b0, dsr_reg});
        rem2   = qbit2 ? DSR_W'(trial2 - {1'b0, dsr_reg}) : trial2[DSR_W-1:0];
    end

    always_comb
    begin
        priority if (fill_reg < FILL_W'(WINDOW))
            diag = DIAG_WARMING;
        else if (spread > spread_lim_reg)
            diag = DIAG_UNSTABLE;
        else if (mean_reg < low_lim_reg)
            diag = DIAG_STUCK_LOW;
        else if (mean_reg > high_lim_reg)
            diag = DIAG_STUCK_HIGH;
        else
            diag = DIAG_STABLE;
    end

    always_comb
    begin
        wpos_next      = wpos_reg;
        fill_next      = fill_reg;
        issue_next     = issue_reg;
        rd_valid_next  = 1'b0;
        steps_next     = steps_reg;
        out_valid_next = out_valid_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        quo_next       = quo_reg;
        mean_next      = mean_reg;
        pct_next       = pct_reg;

        if (cmd.accept)
        begin
            wpos_next  = (wpos_reg == PTR_W'(WINDOW - 1)) ? '0 : wpos_reg + PTR_W'(1);
            fill_next  = (fill_reg < FILL_W'(WINDOW)) ? fill_reg + FILL_W'(1) : fill_reg;
            issue_next = '0;
            lo_next    = '1;
            hi_next    = '0;
            sum_next   = '0;
        end

        if (issuing)
        begin
            issue_next    = issue_reg + FILL_W'(1);
            rd_valid_next = 1'b1;
        end

        if (rd_valid_reg)
        begin
            if (rd_data_reg < lo_reg)
                lo_next = rd_data_reg;
            if (rd_data_reg > hi_reg)
                hi_next = rd_data_reg;
            sum_next = sum_reg + SUM_W'(rd_data_reg);
        end

        if (cmd.div_load_mean)
        begin
            rem_next   = '0;
            quo_next   = DVD_W'(sum_reg);
            dsr_next   = DSR_W'(fill_reg);
            steps_next = STEP_W'(DIV_STEPS);
        end
        else if (cmd.pct_setup && !pct_direct)
        begin
            rem_next   = '0;
            quo_next   = DVD_W'(pct_num);
            dsr_next   = DSR_W'(full_reg - empty_reg);
            steps_next = STEP_W'(DIV_STEPS);
        end
        else if (cmd.div_step && (steps_reg != '0))
        begin
            rem_next   = rem2;
            quo_next   = {quo_reg[DVD_W-3:0], qbit1, qbit2};
            steps_next = steps_reg - STEP_W'(1);
        end

        if (cmd.mean_latch)
            mean_next = quo_reg[SAMPLE_BITS-1:0];

        if (cmd.pct_setup && pct_direct)
            pct_next = (mean_reg <= empty_reg) ? '0 : PCT_FULL;
        else if (cmd.pct_latch)
            pct_next = quo_reg[PCT_W-1:0];

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg      <= '0;
            fill_reg      <= '0;
            issue_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wpos_reg      <= wpos_next;
            fill_reg      <= fill_next;
            issue_reg     <= issue_next;
            rd_valid_reg  <= rd_valid_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        sum_reg  <= sum_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        quo_reg  <= quo_next;
        mean_reg <= mean_next;
        pct_reg  <= pct_next;
        if (cmd.load_out)
        begin
            o_min_reg    <= lo_reg;
            o_max_reg    <= hi_reg;
            o_mean_reg   <= mean_reg;
            o_spread_reg <= spread;
            o_pct_reg    <= pct_reg;
            o_diag_reg   <= diag;
            o_fill_reg   <= fill_reg;
        end
    end

    assign status.scan_done  = (issue_reg == fill_reg) && !rd_valid_reg;
    assign status.div_done   = (steps_reg == '0);
    assign status.pct_direct = pct_direct;
    assign status.out_free   = !out_valid_reg || results.ready;

    assign results.valid         = out_valid_reg;
    assign results.window_min    = o_min_reg;
    assign results.window_max    = o_max_reg;
    assign results.window_mean   = o_mean_reg;
    assign results.window_spread = o_spread_reg;
    assign results.tank_percent  = o_pct_reg;
    assign results.diagnosis     = o_diag_reg;
    assign results.fill_level    = o_fill_reg;

endmodule

### rtl/core/adc_window_level_monitor_top.sv
// Top level of the sliding-window ADC level monitor.
`timescale 1ns / 1ps
//
// Usage:
//   samples : one 12-bit ADC reading per item (valid/ready).
//   results : one item per sample: min, max, floor mean and spread over the
//             filled window, tank percent, diagnosis and fill level.
//   cfg     : register writes (index 0 empty level, 1 full level, 2 spread
//             limit, 3 low limit, 4 high limit); always ready, write only
//             while no sample is in flight. Other indexes are dropped.
// Flow: one item at a time. An item's work runs from acceptance through
//   a scan of the ring through the single read port of the sample memory,
//   then two passes of the shared divider that retires two quotient bits
//   a cycle (mean, then percentage); the percentage pass is skipped when
//   the percentage clamps at 0 or 100. The result is then registered, and
//   the next sample is taken only once the sequencer is back in idle.
// Stall: the result sits in an output register; the next sample is taken
//   and processed meanwhile, and only the final load waits for the slot.
// Reset: window empty, write position zero, registers at their defaults.
//   The sample memory is not cleared; only written entries are ever read.

module adc_window_level_monitor_top import awlm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    awlm_sample_if.sink   samples,
    awlm_result_if.source results,
    awlm_cfg_if.sink      cfg
);

    awlm_cmd_t    cmd;
    awlm_status_t status;

    // Sequencer owns input ready and steps the datapath
    awlm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Ring, accumulators, divider, config and result registers
    awlm_dp u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (samples.sample),
        .cmd     (cmd),
        .status  (status),
        .cfg     (cfg),
        .results (results)
    );

    // A result never appears right after a sample is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> !$rose(results.valid))
        else $error("result raised one cycle after accept");

    // Window always holds at least the newest sample
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.fill_level != '0))
        else $error("result with empty window");

    // Warming diagnosis exactly while the window is filling
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> ((results.diagnosis == DIAG_WARMING)
                           == (results.fill_level < FILL_W'(WINDOW))))
        else $error("warming diagnosis mismatch");

    // Mean lies between min and max
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> ((results.window_min <= results.window_mean)
                           && (results.window_mean <= results.window_max)))
        else $error("mean outside min/max");

endmodule

### verif/adc_window_level_monitor_top_test.sv
// Self-checking testbench for the sliding-window ADC level monitor top level.
`timescale 1ns / 1ps

module adc_window_level_monitor_top_test;
    import awlm_pkg::*;

    // Run limits for the whole run of roughly 1200 items; ITEM_LATENCY is the
    // estimate used for one full-window item.
    localparam int ITEM_LATENCY   = WINDOW + 27;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int HOLD_CYCLES    = 600;
    localparam int MAX_PRINTED    = 60;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
    localparam int IDLE_PCT       = 12;

    // Register indexes past the last defined one; the block drops them.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(CFG_HIGH_LIMIT + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = {CFG_IDX_W{1'b1}};

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] window_min;
        logic [SAMPLE_BITS-1:0] window_max;
        logic [SAMPLE_BITS-1:0] window_mean;
        logic [SAMPLE_BITS-1:0] window_spread;
        logic [PCT_W-1:0]       tank_percent;
        diag_t                  diagnosis;
        logic [FILL_W-1:0]      fill_level;
    } level_report_t;

    logic clk = 1'b0;
    logic rst_n;

    awlm_sample_if sample_ch ();
    awlm_result_if result_ch ();
    awlm_cfg_if    cfg_ch ();

    adc_window_level_monitor_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    always #1 clk = ~clk;

    // Shadow of the block: sample ring, write pointer, fill count, registers.
    logic [SAMPLE_BITS-1:0] ring_store [WINDOW];
    int                     ring_wr;
    int                     ring_fill;
    logic [SAMPLE_BITS-1:0] empty_lvl;
    logic [SAMPLE_BITS-1:0] full_lvl;
    logic [SAMPLE_BITS-1:0] spread_lim;
    logic [SAMPLE_BITS-1:0] low_lim;
    logic [SAMPLE_BITS-1:0] high_lim;

    level_report_t pending_reports [$];

    int  mismatch_count = 0;
    int  report_count   = 0;
    int  cycle_count    = 0;
    int  sample_idle_pct = IDLE_PCT;
    int  result_idle_pct = IDLE_PCT;
    logic result_hold   = 1'b0;

    function automatic void reset_shadow();
        empty_lvl  = EMPTY_RST;
        full_lvl   = FULL_RST;
        spread_lim = SPREAD_RST;
        low_lim    = LOW_RST;
        high_lim   = HIGH_RST;
        ring_wr    = 0;
        ring_fill  = 0;
    endfunction

    // Window statistics, tank percentage and diagnosis after one new sample.
    function automatic level_report_t predict_level(input logic [SAMPLE_BITS-1:0] s);
        level_report_t r;
        int lo;
        int hi;
        int sum;
        int mean;
        int spread;
        int pct;
        int e;
        int f;
        diag_t d;
        ring_store[ring_wr] = s;
        ring_wr = (ring_wr + 1) % WINDOW;
        if (ring_fill < WINDOW)
            ring_fill++;
        lo  = SAMPLE_MAX;
        hi  = 0;
        sum = 0;
        for (int i = 0; i < ring_fill; i++)
        begin
            if (int'(ring_store[i]) < lo)
                lo = int'(ring_store[i]);
            if (int'(ring_store[i]) > hi)
                hi = int'(ring_store[i]);
            sum += int'(ring_store[i]);
        end
        mean   = sum / ring_fill;
        spread = hi - lo;
        e = int'(empty_lvl);
        f = int'(full_lvl);
        // Clamps are tested first, so an inverted or equal pair never divides.
        if (mean <= e)
            pct = 0;
        else if (mean >= f)
            pct = 100;
        else
            pct = ((mean - e) * 100) / (f - e);
        if (ring_fill < WINDOW)
            d = DIAG_WARMING;
        else if (spread > int'(spread_lim))
            d = DIAG_UNSTABLE;
        else if (mean < int'(low_lim))
            d = DIAG_STUCK_LOW;
        else if (mean > int'(high_lim))
            d = DIAG_STUCK_HIGH;
        else
            d = DIAG_STABLE;
        r.window_min    = SAMPLE_BITS'(lo);
        r.window_max    = SAMPLE_BITS'(hi);
        r.window_mean   = SAMPLE_BITS'(mean);
        r.window_spread = SAMPLE_BITS'(spread);
        r.tank_percent  = PCT_W'(pct);
        r.diagnosis     = d;
        r.fill_level    = FILL_W'(ring_fill);
        return r;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] clamp_sample(input int v);
        if (v < 0)
            return '0;
        if (v > SAMPLE_MAX)
            return SAMPLE_BITS'(SAMPLE_MAX);
        return SAMPLE_BITS'(v);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch on result %0d: %0s got %0d want %0d",
                     report_count, what, got, want);
    endtask

    // Result side: random ready, long hold on request, and the field check.
    always @(posedge clk)
    begin
        if (result_ch.valid && result_ch.ready)
        begin
            level_report_t w;
            if (pending_reports.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                w = pending_reports.pop_front();
                if (result_ch.window_min !== w.window_min)
                    report_mismatch("window_min", int'(result_ch.window_min),
                                    int'(w.window_min));
                if (result_ch.window_max !== w.window_max)
                    report_mismatch("window_max", int'(result_ch.window_max),
                                    int'(w.window_max));
                if (result_ch.window_mean !== w.window_mean)
                    report_mismatch("window_mean", int'(result_ch.window_mean),
                                    int'(w.window_mean));
                if (result_ch.window_spread !== w.window_spread)
                    report_mismatch("window_spread", int'(result_ch.window_spread),
                                    int'(w.window_spread));
                if (result_ch.tank_percent !== w.tank_percent)
                    report_mismatch("tank_percent", int'(result_ch.tank_percent),
                                    int'(w.tank_percent));
                if (result_ch.diagnosis !== w.diagnosis)
                    report_mismatch("diagnosis", int'(result_ch.diagnosis),
                                    int'(w.diagnosis));
                if (result_ch.fill_level !== w.fill_level)
                    report_mismatch("fill_level", int'(result_ch.fill_level),
                                    int'(w.fill_level));
            end
            report_count++;
        end
        result_ch.ready <= rst_n && !result_hold &&
                           ($urandom_range(99) >= result_idle_pct);
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("adc_window_level_monitor_top verification failed");
            $finish;
        end
    end

    // Offer one sample. valid stays high after acceptance so back-to-back
    // items never drop it; it falls only on an idle gap or a drain.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sample_idle_pct)
            gap++;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        pending_reports.push_back(predict_level(s));
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write; valid is left high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [SAMPLE_BITS-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_EMPTY_LEVEL:  empty_lvl  = val;
            CFG_FULL_LEVEL:   full_lvl   = val;
            CFG_SPREAD_LIMIT: spread_lim = val;
            CFG_LOW_LIMIT:    low_lim    = val;
            CFG_HIGH_LIMIT:   high_lim   = val;
            default: ;
        endcase
    endtask

    // Full register set, preceded by a write to an unused index that the
    // block must drop. Only called with no sample in flight.
    task automatic program_levels(input int e, input int f, input int s,
                                  input int lo, input int hi);
        drain_results();
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
                  SAMPLE_BITS'($urandom_range(SAMPLE_MAX)));
        write_reg(CFG_EMPTY_LEVEL, SAMPLE_BITS'(e));
        write_reg(CFG_FULL_LEVEL, SAMPLE_BITS'(f));
        write_reg(CFG_SPREAD_LIMIT, SAMPLE_BITS'(s));
        write_reg(CFG_LOW_LIMIT, SAMPLE_BITS'(lo));
        write_reg(CFG_HIGH_LIMIT, SAMPLE_BITS'(hi));
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int pick_level();
        case ($urandom_range(3))
            0:       return 0;
            1:       return SAMPLE_MAX;
            default: return $urandom_range(SAMPLE_MAX);
        endcase
    endfunction

    // A run around one level with bounded jitter; about one item in ten is
    // a wild reading to break the pattern.
    task automatic send_level_run(input int count, input int base, input int jitter);
        int v;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 10)
                v = $urandom_range(SAMPLE_MAX);
            else
                v = base + $urandom_range(2 * jitter) - jitter;
            send_sample(clamp_sample(v));
        end
    endtask

    // Slow sweep over the whole ADC range.
    task automatic send_ramp(input int count, input int jitter);
        for (int i = 0; i < count; i++)
            send_sample(clamp_sample((i * SAMPLE_MAX) / (count - 1)
                                     + $urandom_range(2 * jitter) - jitter));
    endtask

    // Reset defaults; warming window fed with extremes and bit patterns.
    task automatic test_directed_extremes();
        logic [SAMPLE_BITS-1:0] pattern [24];
        pattern = '{12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h800, 12'h7FF,
                    12'hAAA, 12'h555, 12'h001, 12'hFFE, 12'h002, 12'hFFD,
                    12'h028, 12'h027, 12'hFD2, 12'hFD3, 12'h190, 12'h191,
                    12'hF0F, 12'h0F0, 12'h3C3, 12'hC3C, 12'hFFF, 12'h000};
        foreach (pattern[i])
            send_sample(pattern[i]);
        drain_results();
    endtask

    // Default limits: runs near the low end, near the high end, then at mid level with narrow and wide jitter.
    task automatic test_diagnosis_classes();
        program_levels(int'(EMPTY_RST), int'(FULL_RST), int'(SPREAD_RST),
                       int'(LOW_RST), int'(HIGH_RST));
        send_level_run(60, 10, 6);
        send_level_run(60, 4085, 6);
        send_level_run(60, 2000, 60);
        send_level_run(60, 2000, 1500);
    endtask

    // Tank mapping with a normal span, equal levels and inverted levels.
    task automatic test_tank_mapping();
        int e;
        program_levels(500, 3500, 4095, 0, 4095);
        send_ramp(50, 20);
        program_levels(0, 0, 4095, 0, 4095);
        send_ramp(50, 20);
        program_levels(4095, 0, 400, 40, 4050);
        send_ramp(50, 20);
        program_levels(2048, 2048, 400, 40, 4050);
        send_ramp(50, 20);
        e = $urandom_range(4000);
        program_levels(e, $urandom_range(SAMPLE_MAX, e + 1), 400, 40, 4050);
        send_ramp(50, 40);
    endtask

    // Limit registers at their extremes, where one class swallows the rest.
    task automatic test_limit_extremes();
        program_levels(0, 4095, 0, 0, 0);
        send_level_run(20, 0, 0);
        send_level_run(20, $urandom_range(SAMPLE_MAX), 3);
        program_levels(0, 4095, 4095, 4095, 4095);
        send_level_run(20, 4095, 0);
        send_level_run(20, $urandom_range(SAMPLE_MAX), 3);
        program_levels(4095, 4095, 4095, 0, 4095);
        send_level_run(20, 4095, 0);
        send_level_run(20, $urandom_range(SAMPLE_MAX), 200);
        program_levels(0, 0, 400, 40, 4050);
        send_level_run(20, 0, 0);
        send_level_run(20, $urandom_range(SAMPLE_MAX), 3);
        program_levels(4095, 4095, 0, 4095, 0);
        send_level_run(40, 2048, 2048);
    endtask

    // Receiver holds off for a long stretch while samples keep coming, so the
    // output register and the datapath fill and the input stalls.
    task automatic test_result_backpressure();
        program_levels(pick_level(), pick_level(), pick_level(), pick_level(),
                       pick_level());
        fork
            begin
                result_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_hold <= 1'b0;
            end
            begin
                send_level_run(30, $urandom_range(SAMPLE_MAX), 100);
            end
        join
        drain_results();
    endtask

    // Both sides always ready: items arrive as fast as the block takes them.
    task automatic test_no_idle_stretch();
        program_levels(int'(EMPTY_RST), int'(FULL_RST), int'(SPREAD_RST),
                       int'(LOW_RST), int'(HIGH_RST));
        sample_idle_pct = 0;
        result_idle_pct = 0;
        for (int i = 0; i < 150; i++)
            send_sample(SAMPLE_BITS'($urandom_range(SAMPLE_MAX)));
        drain_results();
        sample_idle_pct = IDLE_PCT;
        result_idle_pct = IDLE_PCT;
    endtask

    // Random register sets, each followed by a mix of run shapes.
    task automatic test_random_mix();
        for (int p = 0; p < 7; p++)
        begin
            program_levels(pick_level(), pick_level(), $urandom_range(SAMPLE_MAX),
                           $urandom_range(SAMPLE_MAX), $urandom_range(SAMPLE_MAX));
            case ($urandom_range(2))
                0:       send_level_run(45, pick_level(), $urandom_range(300));
                1:       send_ramp(45, $urandom_range(100));
                default:
                begin
                    for (int i = 0; i < 45; i++)
                        send_sample(SAMPLE_BITS'($urandom_range(SAMPLE_MAX)));
                end
            endcase
        end
    endtask

    initial
    begin
        // Every block input known from time zero.
        rst_n            = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_EMPTY_LEVEL;
        cfg_ch.data      = '0;
        result_ch.ready  = 1'b0;
        reset_shadow();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_diagnosis_classes();
        test_tank_mapping();
        test_limit_extremes();
        test_result_backpressure();
        test_no_idle_stretch();
        test_random_mix();

        // Let the last results out, then a margin of a couple of items.
        drain_results();
        repeat (2 * ITEM_LATENCY) @(posedge clk);
        if (mismatch_count == 0)
            $display("adc_window_level_monitor_top verification clean");
        else
            $display("adc_window_level_monitor_top verification failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/awlm_pkg.sv
rtl/core/awlm_if.sv
rtl/core/awlm_ctrl.sv
rtl/core/awlm_dp.sv
rtl/core/adc_window_level_monitor_top.sv
verif/adc_window_level_monitor_top_test.sv
